### src/dnch_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dnch_pkg
// Shared widths, status codes and register indexes of the neighbor counter.
// ----------------------------------------------------------------------------
package dnch_pkg;

	localparam int unsigned CmdW   = 1;
	localparam int unsigned IdW    = 8;
	localparam int unsigned StatW  = 2;
	localparam int unsigned CntW   = 6;
	localparam int unsigned WinW   = 16;
	localparam int unsigned ThrW   = 6;
	localparam int unsigned CfgIdxW = 2;
	localparam int unsigned CfgDatW = 16;

	typedef logic [StatW-1:0] status_t;
	typedef logic [CfgIdxW-1:0] cfg_idx_t;

	localparam status_t STAT_NONE  = 2'd0;
	localparam status_t STAT_NEW   = 2'd1;
	localparam status_t STAT_KNOWN = 2'd2;
	localparam status_t STAT_DROP  = 2'd3;

	localparam logic [CmdW-1:0] CMD_MSG  = 1'b0;
	localparam logic [CmdW-1:0] CMD_TICK = 1'b1;

	localparam cfg_idx_t REG_WINDOW = 2'd0;
	localparam cfg_idx_t REG_ENTER  = 2'd1;
	localparam cfg_idx_t REG_LEAVE  = 2'd2;

	localparam logic [WinW-1:0] WINDOW_RST = 16'd64;
	localparam logic [ThrW-1:0] ENTER_RST  = 6'd4;
	localparam logic [ThrW-1:0] LEAVE_RST  = 6'd1;

endpackage
`default_nettype wire

### src/dnch_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dnch_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module dnch_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 32,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
`default_nettype wire

### src/distinct_neighbor_counter_hysteresis_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// distinct_neighbor_counter_hysteresis_core
// Collects distinct neighbor IDs per sampling window and applies a
// two-threshold hysteresis mode on the count at each window close.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake          Payload
// in       sink       in_valid/in_ready  command, neighbor_id
// out      source     out_valid/out_ready id_status, sampled, neighbor_count,
//                                        applied_mode, next_mode
// cfg      sink       cfg_valid/cfg_ready cfg_index, cfg_data
//
// A tick or an ID of zero goes from EXEC straight to DONE, with no table scan.
// A message with a nonzero ID scans the stored IDs through the table RAM
// read port, one entry a cycle, until the first match or the last stored entry.
// IDs fill the table in order, so a fill count replaces a clearing pass:
// reset and window close empty the table by clearing the fill count.
// A result waits in the output register while the next request is taken;
// a second finished result holds the sequencer until the register frees.
// ----------------------------------------------------------------------------
module distinct_neighbor_counter_hysteresis_core
	import dnch_pkg::*;
#(
	parameter int unsigned TABLE_SIZE = 32
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic [CmdW-1:0]     command,
	input  wire logic [IdW-1:0]      neighbor_id,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic [StatW-1:0]         id_status,
	output logic                     sampled,
	output logic [CntW-1:0]          neighbor_count,
	output logic                     applied_mode,
	output logic                     next_mode,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [CfgIdxW-1:0]  cfg_index,
	input  wire logic [CfgDatW-1:0]  cfg_data
);

	localparam int unsigned CW   = $clog2(TABLE_SIZE + 1);
	localparam int unsigned AW   = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
	localparam int unsigned CMPW = (CW > ThrW) ? CW : ThrW;
	localparam logic [CW-1:0] FULL = CW'(TABLE_SIZE);
	localparam logic [CMPW-1:0] SAT = CMPW'((1 << CntW) - 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EXEC = 2'd1;
	localparam logic [1:0] ST_SCAN = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0]       state_q;
	logic [WinW-1:0]  window_q;
	logic [ThrW-1:0]  enter_q;
	logic [ThrW-1:0]  leave_q;
	logic [WinW-1:0]  ticks_q;
	logic             mode_q;
	logic [CW-1:0]    fill_q;
	logic [CW-1:0]    addr_q;
	logic             pend_s1;
	logic             out_valid_q;

	logic [CmdW-1:0]  cmd_q;
	logic [IdW-1:0]   id_q;
	status_t          stat_q;
	logic             samp_q;
	logic [CntW-1:0]  cnt_q;
	logic             app_q;

	status_t          o_stat_q;
	logic             o_samp_q;
	logic [CntW-1:0]  o_cnt_q;
	logic             o_app_q;
	logic             o_next_q;

	logic             in_acc;
	logic             rd_en;
	logic [IdW-1:0]   rd_data;
	logic             hit;
	logic             miss_end;
	logic             full;
	logic             wr_en;
	logic             out_load;
	logic [WinW-1:0]  tick_nx;
	logic             close;
	logic [CMPW-1:0]  count_w;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	assign rd_en    = (state_q == ST_SCAN) && (addr_q < fill_q);
	assign hit      = (state_q == ST_SCAN) && pend_s1 && (rd_data == id_q);
	assign miss_end = !rd_en && !pend_s1;
	assign full     = (fill_q == FULL);
	assign wr_en    = (state_q == ST_SCAN) && !hit && miss_end && !full;
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || out_ready);
	assign tick_nx  = ticks_q + WinW'(1);
	assign close    = (tick_nx >= window_q);
	assign count_w  = CMPW'(fill_q);

	dnch_ram #(
		.WIDTH (IdW),
		.DEPTH (TABLE_SIZE)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (fill_q[AW-1:0]),
		.wr_data (id_q),
		.rd_en   (rd_en),
		.rd_addr (addr_q[AW-1:0]),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WINDOW_RST;
			enter_q  <= ENTER_RST;
			leave_q  <= LEAVE_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_WINDOW: window_q <= cfg_data;
				REG_ENTER:  enter_q  <= cfg_data[ThrW-1:0];
				REG_LEAVE:  leave_q  <= cfg_data[ThrW-1:0];
				default:    ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ticks_q     <= '0;
			mode_q      <= 1'b0;
			fill_q      <= '0;
			addr_q      <= '0;
			pend_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					addr_q  <= '0;
					pend_s1 <= 1'b0;
					if (cmd_q == CMD_TICK) begin
						state_q <= ST_DONE;
						if (close) begin
							ticks_q <= '0;
							fill_q  <= '0;
							if (!mode_q && (count_w >= CMPW'(enter_q))) begin
								mode_q <= 1'b1;
							end else if (mode_q && (count_w < CMPW'(leave_q))) begin
								mode_q <= 1'b0;
							end
						end else begin
							ticks_q <= tick_nx;
						end
					end else if (id_q == '0) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					pend_s1 <= rd_en;
					if (rd_en) begin
						addr_q <= addr_q + CW'(1);
					end
					if (hit || miss_end) begin
						state_q <= ST_DONE;
					end
					if (wr_en) begin
						fill_q <= fill_q + CW'(1);
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_q <= command;
			id_q  <= neighbor_id;
		end
		if (state_q == ST_EXEC) begin
			samp_q <= 1'b0;
			cnt_q  <= '0;
			app_q  <= 1'b0;
			if (cmd_q == CMD_TICK) begin
				stat_q <= STAT_NONE;
				if (close) begin
					samp_q <= 1'b1;
					app_q  <= mode_q;
					cnt_q  <= (count_w > SAT) ? CntW'(SAT) : CntW'(count_w);
				end
			end else begin
				stat_q <= STAT_DROP;
			end
		end
		if ((state_q == ST_SCAN) && (hit || miss_end)) begin
			if (hit) begin
				stat_q <= STAT_KNOWN;
			end else if (full) begin
				stat_q <= STAT_DROP;
			end else begin
				stat_q <= STAT_NEW;
			end
		end
		if (out_load) begin
			o_stat_q <= stat_q;
			o_samp_q <= samp_q;
			o_cnt_q  <= cnt_q;
			o_app_q  <= app_q;
			o_next_q <= mode_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign id_status      = o_stat_q;
	assign sampled        = o_samp_q;
	assign neighbor_count = o_cnt_q;
	assign applied_mode   = o_app_q;
	assign next_mode      = o_next_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FULL)
		else $error("fill count beyond table size");

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q == ST_EXEC))
		else $error("accepted request did not start execution");

	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_DONE))
		else $error("result raised outside done state");

	a_hit_no_insert: assert property (@(posedge clk) disable iff (!arst_n)
		hit |=> (fill_q == $past(fill_q)))
		else $error("known ID changed fill count");

	a_sample_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && o_samp_q) |-> (o_stat_q == STAT_NONE))
		else $error("window close reported with message status");

endmodule
`default_nettype wire

### dv/tb_distinct_neighbor_counter_hysteresis_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_distinct_neighbor_counter_hysteresis_core
// Self-checking bench for the neighbor counter. A queue of pending requests,
// register writes and sync points feeds a clocked driver. An in-bench copy of
// the ID table, tick counter and mode predicts each result, and a clocked
// monitor checks every result in order under random output stalls.
// ----------------------------------------------------------------------------
module tb_distinct_neighbor_counter_hysteresis_core;
	import dnch_pkg::*;

	localparam int unsigned TableSize   = 32;
	localparam int unsigned ItemGoal    = 1200;
	localparam int unsigned QuietLimit  = 4000;
	localparam int unsigned SettleCycles = TableSize + 8;

	typedef enum logic [1:0] {
		ENTRY_ITEM,
		ENTRY_WRITE,
		ENTRY_SYNC
	} entry_kind_e;

	typedef struct packed {
		entry_kind_e           kind;
		logic [CmdW-1:0]       cmd;
		logic [IdW-1:0]        nid;
		cfg_idx_t              idx;
		logic [CfgDatW-1:0]    data;
		logic [7:0]            gap;
	} outbox_entry_t;

	typedef struct packed {
		status_t               id_status;
		logic                  sampled;
		logic [CntW-1:0]       neighbor_count;
		logic                  applied_mode;
		logic                  next_mode;
	} neighbor_result_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [CmdW-1:0]     command = CMD_MSG;
	logic [IdW-1:0]      neighbor_id = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [StatW-1:0]    id_status;
	logic                sampled;
	logic [CntW-1:0]     neighbor_count;
	logic                applied_mode;
	logic                next_mode;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	cfg_idx_t            cfg_index = REG_WINDOW;
	logic [CfgDatW-1:0]  cfg_data = '0;

	outbox_entry_t       outbox[$];
	neighbor_result_t    awaited_results[$];
	neighbor_result_t    want;

	logic [IdW-1:0]      roster[TableSize];
	logic [WinW-1:0]     ticks_elapsed = '0;
	logic                mode = 1'b0;
	logic [WinW-1:0]     window_ticks = WINDOW_RST;
	logic [ThrW-1:0]     enter_thr = ENTER_RST;
	logic [ThrW-1:0]     leave_thr = LEAVE_RST;

	bit                  in_busy;
	bit                  cfg_busy;
	bit                  steady;
	int unsigned         gap_left = 0;
	int unsigned         ready_hold = 0;
	int unsigned         quiet_cycles = 0;
	int unsigned         item_total = 0;
	int unsigned         errors = 0;
	int unsigned         accepted_items = 0;
	int unsigned         windows_closed = 0;
	int unsigned         full_drops = 0;
	int unsigned         reg_writes = 0;

	distinct_neighbor_counter_hysteresis_core #(
		.TABLE_SIZE(TableSize)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.command(command),
		.neighbor_id(neighbor_id),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.id_status(id_status),
		.sampled(sampled),
		.neighbor_count(neighbor_count),
		.applied_mode(applied_mode),
		.next_mode(next_mode),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	function automatic int unsigned idle_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic int unsigned next_gap();
		return steady ? 0 : idle_len();
	endfunction

	function automatic logic [CfgDatW-1:0] threshold_data();
		logic [CfgDatW-1:0] d;
		case ($urandom_range(0, 5))
			0: d = '0;
			1: d = 16'd33;
			default: d = CfgDatW'($urandom_range(0, 12));
		endcase
		if ($urandom_range(0, 3) == 0)
			d = d | (CfgDatW'($urandom) & 16'hFFC0);
		return d;
	endfunction

	task automatic send_item(input logic [CmdW-1:0] cmd, input logic [IdW-1:0] nid,
			input int unsigned gap);
		outbox_entry_t e;
		e = '0;
		e.kind = ENTRY_ITEM;
		e.cmd = cmd;
		e.nid = nid;
		e.gap = 8'(gap);
		outbox.push_back(e);
		item_total++;
	endtask

	task automatic send_write(input cfg_idx_t idx, input logic [CfgDatW-1:0] data);
		outbox_entry_t e;
		e = '0;
		e.kind = ENTRY_WRITE;
		e.idx = idx;
		e.data = data;
		outbox.push_back(e);
	endtask

	task automatic send_sync();
		outbox_entry_t e;
		e = '0;
		e.kind = ENTRY_SYNC;
		outbox.push_back(e);
	endtask

	function automatic void track_neighbor_item(input logic [CmdW-1:0] cmd,
			input logic [IdW-1:0] nid);
		neighbor_result_t r;
		int unsigned count;
		bit found;
		bit placed;
		r = '0;
		count = 0;
		found = 1'b0;
		placed = 1'b0;
		if (cmd == CMD_MSG) begin
			r.id_status = STAT_DROP;
			if (nid != '0) begin
				foreach (roster[i])
					if (roster[i] == nid)
						found = 1'b1;
				if (found) begin
					r.id_status = STAT_KNOWN;
				end else begin
					foreach (roster[i]) begin
						if (!placed && roster[i] == '0) begin
							roster[i] = nid;
							placed = 1'b1;
						end
					end
					if (placed)
						r.id_status = STAT_NEW;
					else
						full_drops++;
				end
			end
		end else begin
			r.id_status = STAT_NONE;
			ticks_elapsed = ticks_elapsed + 1'b1;
			if (ticks_elapsed >= window_ticks) begin
				foreach (roster[i]) begin
					if (roster[i] != '0)
						count++;
					roster[i] = '0;
				end
				ticks_elapsed = '0;
				r.sampled = 1'b1;
				r.applied_mode = mode;
				r.neighbor_count = (count > 63) ? '1 : count[CntW-1:0];
				if (!mode) begin
					if (count >= enter_thr)
						mode = 1'b1;
				end else if (count < leave_thr) begin
					mode = 1'b0;
				end
				windows_closed++;
			end
		end
		r.next_mode = mode;
		awaited_results.push_back(r);
	endfunction

	task automatic check_field(input string name, input int unsigned exp_val,
			input int unsigned act_val);
		if (exp_val != act_val) begin
			$display("%0t: %s expected %0d, actual %0d", $time, name, exp_val, act_val);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			cfg_valid <= 1'b0;
			gap_left = 0;
		end else begin
			in_busy = in_valid;
			cfg_busy = cfg_valid;
			if (in_valid && in_ready) begin
				track_neighbor_item(command, neighbor_id);
				accepted_items++;
				in_busy = 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_WINDOW: window_ticks = cfg_data[WinW-1:0];
					REG_ENTER:  enter_thr = cfg_data[ThrW-1:0];
					REG_LEAVE:  leave_thr = cfg_data[ThrW-1:0];
					default: ;
				endcase
				reg_writes++;
				cfg_busy = 1'b0;
			end
			if (!in_busy && !cfg_busy && outbox.size() > 0) begin
				if (gap_left > 0) begin
					gap_left--;
				end else begin
					case (outbox[0].kind)
						ENTRY_ITEM: begin
							command <= outbox[0].cmd;
							neighbor_id <= outbox[0].nid;
							gap_left = outbox[0].gap;
							in_busy = 1'b1;
							void'(outbox.pop_front());
						end
						ENTRY_WRITE: begin
							cfg_index <= outbox[0].idx;
							cfg_data <= outbox[0].data;
							cfg_busy = 1'b1;
							void'(outbox.pop_front());
						end
						default: begin
							// hold until the block has drained
							if (awaited_results.size() == 0)
								void'(outbox.pop_front());
						end
					endcase
				end
			end
			in_valid <= in_busy;
			cfg_valid <= cfg_busy;
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			ready_hold = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (awaited_results.size() == 0) begin
					$display("%0t: unexpected result, status %0d sampled %0d count %0d",
						$time, id_status, sampled, neighbor_count);
					errors++;
				end else begin
					want = awaited_results.pop_front();
					check_field("id_status", want.id_status, id_status);
					check_field("sampled", want.sampled, sampled);
					check_field("neighbor_count", want.neighbor_count, neighbor_count);
					check_field("applied_mode", want.applied_mode, applied_mode);
					check_field("next_mode", want.next_mode, next_mode);
				end
			end
			if (ready_hold > 0) begin
				ready_hold--;
			end else if (out_ready) begin
				out_ready <= 1'b0;
				ready_hold = idle_len();
			end else begin
				out_ready <= 1'b1;
				ready_hold = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
					: $urandom_range(1, 12);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles == QuietLimit) begin
				$display("%0t: no handshake for %0d cycles", $time, QuietLimit);
				$display("FAILURE");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		int unsigned win, gen_window, rounds, msgs, pool, base, ticks;
		foreach (roster[i])
			roster[i] = '0;
		gen_window = WINDOW_RST;
		steady = 1'b0;

		send_item(CMD_MSG, 8'd0, 0);
		send_item(CMD_MSG, 8'd255, 0);
		send_item(CMD_MSG, 8'd255, 1);
		send_item(CMD_MSG, 8'd1, 0);
		send_item(CMD_MSG, 8'hAA, 2);
		send_item(CMD_MSG, 8'h55, 0);
		send_item(CMD_TICK, 8'd0, 0);
		send_sync();
		send_write(REG_WINDOW, 16'd0);
		send_write(REG_ENTER, 16'd0);
		send_write(REG_LEAVE, 16'd0);
		send_item(CMD_TICK, 8'd0, 0);
		send_item(CMD_TICK, 8'hFF, 0);
		send_sync();
		send_write(REG_LEAVE, 16'd33);
		send_write(REG_WINDOW, 16'd2);
		send_item(CMD_TICK, 8'd0, 0);
		send_item(CMD_MSG, 8'd7, 0);
		send_item(CMD_TICK, 8'd0, 0);
		send_sync();
		send_write(REG_ENTER, 16'hFFE1);
		send_write(REG_WINDOW, 16'hFFFF);
		send_write(cfg_idx_t'(3), 16'h5A5A);
		send_item(CMD_TICK, 8'd0, 0);
		send_item(CMD_MSG, 8'd0, 0);
		send_item(CMD_MSG, 8'd200, 0);
		gen_window = 16'hFFFF;

		while (item_total < ItemGoal) begin
			steady = ($urandom_range(0, 3) == 0);
			send_sync();
			case ($urandom_range(0, 9))
				0: win = 0;
				1: win = 1;
				7: win = $urandom_range(9, 40);
				8: win = 16'hFFFF;
				9: win = $urandom_range(41, 65534);
				default: win = $urandom_range(2, 8);
			endcase
			if ($urandom_range(0, 3) != 0) begin
				send_write(REG_WINDOW, CfgDatW'(win));
				gen_window = win;
			end
			if ($urandom_range(0, 3) != 0)
				send_write(REG_ENTER, threshold_data());
			if ($urandom_range(0, 3) != 0)
				send_write(REG_LEAVE, threshold_data());
			if ($urandom_range(0, 9) == 0)
				send_write(cfg_idx_t'(3), CfgDatW'($urandom));
			rounds = $urandom_range(2, 5);
			repeat (rounds) begin
				msgs = $urandom_range(0, 45);
				pool = $urandom_range(1, 48);
				base = $urandom_range(0, 255);
				repeat (msgs) begin
					if ($urandom_range(0, 11) == 0)
						send_item(CmdW'($urandom_range(0, 1)), IdW'($urandom_range(0, 255)),
							next_gap());
					else
						send_item(CMD_MSG, IdW'((base + $urandom_range(0, pool - 1)) % 256),
							next_gap());
				end
				if (gen_window == 0)
					ticks = 1;
				else if (gen_window > 48)
					ticks = $urandom_range(1, 5);
				else
					ticks = gen_window;
				repeat (ticks)
					send_item(CMD_TICK, IdW'($urandom_range(0, 255)), next_gap());
			end
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		while (outbox.size() > 0 || in_valid || cfg_valid || awaited_results.size() > 0)
			@(posedge clk);
		repeat (SettleCycles) @(posedge clk);

		$display("Run covered %0d requests, %0d closed windows, %0d full-table drops",
			accepted_items, windows_closed, full_drops);
		$display("and %0d register writes across window and threshold settings", reg_writes);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

### distinct_neighbor_counter_hysteresis_core.f
src/dnch_pkg.sv
src/dnch_ram.sv
src/distinct_neighbor_counter_hysteresis_core.sv
dv/tb_distinct_neighbor_counter_hysteresis_core.sv
